// ===== src/sliding_window_median_deviation_defines.svh =====
// Assertion macros for the sliding window median deviation block
`ifndef SLIDING_WINDOW_MEDIAN_DEVIATION_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEVIATION_DEFINES_SVH
`ifndef ASSERT_OFF
`define SWMD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SWMD_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SWMD_ASSERT(label, clk, rst_n, prop)
`define SWMD_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== src/swmd_pkg.sv =====
// Shared constants for the sliding window median deviation block
`timescale 1ns / 1ps
`default_nettype none
package swmd_pkg;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int COST_BITS       = 38;
    localparam int CFG_BITS        = 7;
    localparam int DATA_BITS       = 72;
endpackage
`default_nettype wire

// ===== src/swmd_front.sv =====
// Input stage: takes sample beats into a short queue
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_median_deviation_defines.svh"
module swmd_front
    import swmd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_restart,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS:0]        o_item
);
    // two entry queue: restart flag on top of sample
    logic [SAMPLE_BITS:0] r_q [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= {i_restart, i_sample};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `SWMD_ASSERT(a_no_overflow, i_clk, i_rst_n, (r_cnt == 2'd2) |-> !o_ready)
    `SWMD_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
    `SWMD_ASSERT(a_pop_nonempty, i_clk, i_rst_n, w_pop |-> (r_cnt != 2'd0))
endmodule
`default_nettype wire

// ===== src/swmd_back.sv =====
// Sorted cell chain, arrival ring and serial cost accumulation
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_median_deviation_defines.svh"
module swmd_back
    import swmd_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_BITS-1:0]    i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS:0]   i_item,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [COST_BITS-1:0]        o_cost,
    output logic [SAMPLE_BITS-1:0]      o_median
);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [2:0] {S_IDLE, S_REMOVE, S_INSERT, S_SUM, S_OUT} t_state;

    t_state                          r_state;
    logic signed [SAMPLE_BITS-1:0]   r_cell [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]   r_ring [WINDOW_MAX];
    logic [CW-1:0]                   r_k, r_fill;
    logic [IW-1:0]                   r_oldest, r_wpos;
    logic signed [SAMPLE_BITS-1:0]   r_x, r_old, r_med;
    logic [CW-1:0]                   r_i;
    logic signed [COST_BITS-1:0]     r_acc;
    logic                            r_full;
    logic [COST_BITS-1:0]            r_cost;
    logic [SAMPLE_BITS-1:0]          r_med_o;
    logic                            r_ovalid;
    logic [CW-1:0]                   w_kin;
    logic [IW:0]                     w_sum;
    logic [IW-1:0]                   w_opos;
    logic signed [COST_BITS-1:0]     w_d;
    logic [WINDOW_MAX-1:0]           w_match, w_gt, w_act;
    logic [WINDOW_MAX-1:0]           w_mpre;
    logic                            w_load;

    // effective window size from the config value
    always_comb begin
        if (i_cfg_data == '0) w_kin = CW'(1);
        else if ({{(32-CFG_BITS){1'b0}}, i_cfg_data} > 32'(WINDOW_MAX)) w_kin = CW'(WINDOW_MAX);
        else w_kin = CW'(i_cfg_data);
    end

    // per-cell compare flags
    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            w_act[j]   = (CW'(j) < r_fill);
            w_match[j] = w_act[j] && (r_cell[j] == r_old);
            w_gt[j]    = w_act[j] && (r_cell[j] > r_x);
        end
        w_mpre[0] = 1'b0;
        for (int j = 1; j < WINDOW_MAX; j++) w_mpre[j] = w_mpre[j-1] | w_match[j-1];
    end

    assign w_sum  = {1'b0, r_oldest} + {1'b0, r_fill[IW-1:0]};
    assign w_opos = (CW'(w_sum) >= r_k) ? IW'(CW'(w_sum) - r_k) : w_sum[IW-1:0];
    assign w_d    = COST_BITS'(r_cell[r_i[IW-1:0]]) - COST_BITS'(r_med);

    // result register loads once the sum is done and the output slot is free
    assign w_load = (r_state == S_OUT) && (r_i >= r_k) && (!r_ovalid || i_ready);

    assign o_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_valid  = r_ovalid;
    assign o_cost   = r_cost;
    assign o_median = r_med_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= CW'(3 > WINDOW_MAX ? WINDOW_MAX : 3);
            r_fill   <= '0;
            r_oldest <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_k      <= w_kin;
                r_fill   <= '0;
                r_oldest <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_valid) begin
                            r_x <= i_item[SAMPLE_BITS-1:0];
                            if (i_item[SAMPLE_BITS]) begin
                                r_fill   <= '0;
                                r_oldest <= '0;
                                r_full   <= 1'b0;
                                r_wpos   <= '0;
                                r_state  <= S_INSERT;
                            end else if (r_fill >= r_k) begin
                                r_full  <= 1'b1;
                                r_old   <= r_ring[r_oldest];
                                r_wpos  <= r_oldest;
                                r_state <= S_REMOVE;
                            end else begin
                                r_full  <= 1'b0;
                                r_wpos  <= w_opos;
                                r_state <= S_INSERT;
                            end
                        end
                    end
                    S_REMOVE: begin
                        // drop first cell holding the evicted value, shift tail down
                        for (int j = 0; j < WINDOW_MAX - 1; j++) begin
                            if (w_mpre[j] || w_match[j]) r_cell[j] <= r_cell[j+1];
                        end
                        if (|w_match) r_fill <= r_fill - CW'(1);
                        r_oldest <= (CW'(r_oldest) + CW'(1) >= r_k) ? '0 : r_oldest + IW'(1);
                        r_state  <= S_INSERT;
                    end
                    S_INSERT: begin
                        // open a slot above larger cells
                        if (r_fill < CW'(WINDOW_MAX)) begin
                            for (int j = 1; j < WINDOW_MAX; j++) begin
                                if (w_gt[j-1] && CW'(j) <= r_fill) r_cell[j] <= r_cell[j-1];
                            end
                            for (int j = 0; j < WINDOW_MAX; j++) begin
                                if (CW'(j) <= r_fill && !w_gt[j] &&
                                    (j == 0 || !w_gt[j == 0 ? 0 : j-1] ? 1'b1 : 1'b0) &&
                                    (CW'(j) == r_fill || w_gt[j])) begin
                                    r_cell[j] <= r_x;
                                end
                                if (CW'(j) <= r_fill && w_gt[j] &&
                                    (j == 0 || !w_gt[j == 0 ? 0 : j-1])) begin
                                    r_cell[j] <= r_x;
                                end
                            end
                            r_fill <= r_fill + CW'(1);
                        end
                        r_ring[r_wpos] <= r_x;
                        if (r_full || r_fill + CW'(1) >= r_k) begin
                            r_i     <= '0;
                            r_acc   <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_SUM: begin
                        if (r_i == '0) begin
                            r_med <= r_cell[IW'((r_k - CW'(1)) >> 1)];
                            r_i   <= CW'(1) - CW'(1);
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        // one cell per cycle unless a config write holds it: add absolute deviation
                        if (r_i < r_k) begin
                            r_acc <= r_acc + (w_d[COST_BITS-1] ? -w_d : w_d);
                            r_i   <= r_i + CW'(1);
                        end else if (w_load) begin
                            r_cost   <= r_acc;
                            r_med_o  <= r_med;
                            r_state  <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    `SWMD_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(WINDOW_MAX))
    `SWMD_ASSERT(a_hold_out, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
    `SWMD_ASSERT(a_one_match, i_clk, i_rst_n, (r_state == S_REMOVE) |-> $onehot0(w_match & ~w_mpre))
endmodule
`default_nettype wire

// ===== src/sliding_window_median_deviation.sv =====
// Top level of the sliding window median deviation block
`timescale 1ns / 1ps
`default_nettype none
// Keeps the last window_size samples in arrival order and in a sorted cell
// chain; once full, each sample beat evicts the oldest and yields the lower
// median and the sum of absolute deviations. With a full window the back end
// is busy per beat through accept, remove, insert, median pick, accumulate
// steps over the window cells and result load; the beat that fills the window
// skips the remove step, and a beat that only fills the window goes through
// accept and insert alone. A beat passes the input queue before the back end
// takes it, and a result not yet taken holds the back end at the load step.
// A two-beat input queue lets the next sample land while one is at work.
module sliding_window_median_deviation
    import swmd_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_BITS-1:0]   i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample
    input  wire logic                  s_axis_tuser,  // restart
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [((COST_BITS+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata // cost, median
);
    localparam int OW = ((COST_BITS + SAMPLE_BITS + 7) / 8) * 8;

    logic                   w_fv, w_fr;
    logic [SAMPLE_BITS:0]   w_item;
    logic [COST_BITS-1:0]   w_cost;
    logic [SAMPLE_BITS-1:0] w_med;

    swmd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sample(s_axis_tdata[SAMPLE_BITS-1:0]), .i_restart(s_axis_tuser),
        .o_valid(w_fv), .i_ready(w_fr), .o_item(w_item)
    );

    swmd_back #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_valid(w_fv), .o_ready(w_fr), .i_item(w_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_cost(w_cost), .o_median(w_med)
    );

    assign m_axis_tdata = OW'({w_med, w_cost});
endmodule
`default_nettype wire

// ===== tb/sv/sliding_window_median_deviation_checker.sv =====
// Checker for the sliding window median deviation block: predicts and compares results
`timescale 1ns / 1ps
module sliding_window_median_deviation_checker
    import swmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [31:0]          i_in_data,    // sample
    input  logic                 i_in_user,    // restart
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [71:0]          i_out_data,   // cost, median
    output int                   o_fail_count,
    output int                   o_pending
);
    typedef struct packed {
        logic [31:0] median;
        logic [37:0] cost;
    } t_swmd_result;

    t_swmd_result      expected_results[$];
    int unsigned       win_size;
    logic signed [31:0] ring[64];
    logic signed [31:0] sorted_win[$];
    int unsigned       fill;
    int unsigned       oldest;

    // effective window size after clamping
    function automatic int unsigned clamp_size(int unsigned v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return v;
    endfunction

    // window update for one sample; pushes a result once full
    task automatic take_sample(logic signed [31:0] x, logic rst_win);
        int unsigned  k;
        int unsigned  pos;
        int           idx;
        longint       med;
        longint       acc;
        longint       d;
        t_swmd_result r;
        k = clamp_size(win_size);
        if (rst_win) begin
            fill = 0;
            oldest = 0;
            sorted_win.delete();
        end
        if (fill >= k) begin
            pos = oldest % k;
            foreach (sorted_win[j]) begin
                if (sorted_win[j] == ring[pos]) begin
                    sorted_win.delete(j);
                    break;
                end
            end
            ring[pos] = x;
            oldest = (pos + 1) % k;
        end else begin
            ring[(oldest + fill) % k] = x;
            fill++;
        end
        idx = 0;
        while (idx < sorted_win.size() && sorted_win[idx] <= x) idx++;
        sorted_win.insert(idx, x);
        if (fill < k) return;
        med = sorted_win[(k - 1) / 2];
        acc = 0;
        foreach (sorted_win[j]) begin
            d = longint'(sorted_win[j]) - med;
            acc += (d < 0) ? -d : d;
        end
        r.cost = acc[37:0];
        r.median = med[31:0];
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_swmd_result got;
        t_swmd_result want;
        int           nfail;
        nfail = 0;
        if (!i_rst_n) begin
            win_size <= 3;
            fill = 0;
            oldest = 0;
            sorted_win.delete();
            expected_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                win_size <= 32'(i_cfg_data);
                fill = 0;
                oldest = 0;
                sorted_win.delete();
            end
            if (i_in_valid && i_in_ready) take_sample(i_in_data, i_in_user);
            // compare the result beat with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[69:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat cost=%0d median=%0d",
                             $time, got.cost, $signed(got.median));
                    nfail++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.cost !== want.cost) begin
                        $display("%0t: cost expected %0d actual %0d",
                                 $time, want.cost, got.cost);
                        nfail++;
                    end
                    if (got.median !== want.median) begin
                        $display("%0t: median expected %0d actual %0d", $time,
                                 $signed(want.median), $signed(got.median));
                        nfail++;
                    end
                end
            end
            o_fail_count <= o_fail_count + nfail;
            o_pending <= expected_results.size();
        end
    end
endmodule

// ===== tb/sv/sliding_window_median_deviation_tb.sv =====
// Top of the sliding window median deviation testbench: stimulus and verdict
`timescale 1ns / 1ps
module sliding_window_median_deviation_tb;
    import swmd_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata = '0;   // sample
    logic                s_axis_tuser = 1'b0; // restart
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [71:0]         m_axis_tdata;        // cost, median
    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    bit                  calm = 1'b0;
    bit                  hold_sink = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sliding_window_median_deviation uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    sliding_window_median_deviation_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sliding_window_median_deviation test failed");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_sink) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end

    // one sample beat, with a random gap ahead of it when not calm; valid stays up after it
    task automatic send_sample(logic [31:0] x, logic rs);
        while (!calm && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= rs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // wait until idle, then write the window size
    task automatic set_size(logic [CFG_BITS-1:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // a sample stream that fills the window and runs past it
    task automatic run_stream(int n);
        for (int i = 0; i < n; i++)
            send_sample(rand_sample(), (i == 0) || ($urandom_range(99) < 2));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size, extremes, duplicates, restart mid-window, clamped and small sizes
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        set_size(7'd0);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        set_size(7'd127);
        for (int i = 0; i < 66; i++)
            send_sample((i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0);
        set_size(7'd2);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'h5555_5555, 1'b0);

        // random phases over several window sizes
        set_size(7'd4);
        run_stream(150);
        set_size(7'd64);
        calm = 1'b1;
        hold_sink = 1'b1;
        fork
            run_stream(130);
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
        join
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        set_size(7'd1);
        run_stream(150);
        set_size(7'd5);
        run_stream(250);
        set_size(7'd65);
        run_stream(100);
        for (int p = 0; p < 6; p++) begin
            set_size(CFG_BITS'($urandom_range(2, 12)));
            run_stream(60);
        end
        set_size(7'd9);
        run_stream(50);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0) $display("sliding_window_median_deviation test passed");
        else $display("sliding_window_median_deviation test failed");
        $finish;
    end
endmodule
